### rtl/ps2hbe_pkg.sv
// Package for the PS/2 host bit engine: word types, event codes, frame positions, parity.
`timescale 1ns / 1ps

package ps2hbe_pkg;

    // Event codes carried in the kind field
    localparam logic [2:0] KIND_RX_EDGE  = 3'd0;
    localparam logic [2:0] KIND_TX_EDGE  = 3'd1;
    localparam logic [2:0] KIND_TX_START = 3'd2;
    localparam logic [2:0] KIND_RX_CLEAR = 3'd3;
    localparam logic [2:0] KIND_TX_CLEAR = 3'd4;

    // Receive frame positions
    localparam logic [3:0] RX_POS_IDLE   = 4'd0;
    localparam logic [3:0] RX_POS_DATA0  = 4'd1;
    localparam logic [3:0] RX_POS_DATA7  = 4'd8;
    localparam logic [3:0] RX_POS_PARITY = 4'd9;
    localparam logic [3:0] RX_POS_STOP   = 4'd10;

    // Transmit frame positions
    localparam logic [3:0] TX_POS_FIRST  = 4'd0;
    localparam logic [3:0] TX_POS_PARITY = 4'd8;
    localparam logic [3:0] TX_POS_STOP   = 4'd9;
    localparam logic [3:0] TX_POS_ACK    = 4'd10;

    // Input word
    typedef struct packed {
        logic [2:0] kind;
        logic       line_in;
        logic [7:0] send_byte;
    } item_t;

    // Result word
    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic [7:0] recv_byte;
        logic       recv_parity;
        logic       recv_done;
        logic       send_busy;
        logic       send_done;
    } result_t;

    // Engine state
    typedef struct packed {
        logic [3:0] rx_position;
        logic [7:0] rx_shift;
        logic [7:0] rx_latched;
        logic       rx_parity_bit;
        logic       rx_ready;
        logic [3:0] tx_position;
        logic [7:0] tx_data;
        logic       tx_active;
        logic       tx_finished;
        logic       drive_level;
        logic       drive_on;
    } state_t;

    // XOR of all bits of a byte
    function automatic logic byte_parity(input logic [7:0] value);
        byte_parity = ^value;
    endfunction

endpackage

### rtl/ps2hbe_core.sv
// State registers and per-event update logic of the PS/2 host bit engine.
`timescale 1ns / 1ps

module ps2hbe_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  ps2hbe_pkg::item_t    item,
    output ps2hbe_pkg::result_t  result
);
    import ps2hbe_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] rx_index;

    assign rx_index = 3'(state_reg.rx_position - RX_POS_DATA0);

    // Compute the state after this event
    always_comb
    begin
        state_next = state_reg;
        case (item.kind)
            KIND_RX_EDGE:
            begin
                if (state_reg.rx_position == RX_POS_IDLE)
                begin
                    if (!item.line_in && !state_reg.rx_ready)
                        state_next.rx_position = RX_POS_DATA0;
                end
                else if (state_reg.rx_position inside {[RX_POS_DATA0:RX_POS_DATA7]})
                begin
                    if (item.line_in)
                        state_next.rx_shift = state_reg.rx_shift | (8'd1 << rx_index);
                    state_next.rx_position = state_reg.rx_position + 4'd1;
                end
                else if (state_reg.rx_position == RX_POS_PARITY)
                begin
                    state_next.rx_parity_bit = item.line_in;
                    state_next.rx_position   = RX_POS_STOP;
                end
                else if (state_reg.rx_position == RX_POS_STOP)
                begin
                    // Low stop bit: hold position and look again next edge
                    if (item.line_in)
                    begin
                        state_next.rx_latched  = state_reg.rx_shift;
                        state_next.rx_ready    = 1'b1;
                        state_next.rx_position = RX_POS_IDLE;
                        state_next.rx_shift    = 8'd0;
                    end
                end
                else
                begin
                    // Stray position: drop back to idle
                    state_next.rx_position = RX_POS_IDLE;
                    state_next.rx_shift    = 8'd0;
                end
            end
            KIND_TX_EDGE:
            begin
                if (state_reg.tx_active)
                begin
                    if (state_reg.tx_position < TX_POS_PARITY)
                    begin
                        state_next.drive_level = state_reg.tx_data[state_reg.tx_position[2:0]];
                        state_next.tx_position = state_reg.tx_position + 4'd1;
                    end
                    else if (state_reg.tx_position == TX_POS_PARITY)
                    begin
                        state_next.drive_level = byte_parity(state_reg.tx_data);
                        state_next.tx_position = TX_POS_STOP;
                    end
                    else if (state_reg.tx_position == TX_POS_STOP)
                    begin
                        // Stop bit slot: release the line
                        state_next.drive_level = 1'b1;
                        state_next.drive_on    = 1'b0;
                        state_next.tx_position = TX_POS_ACK;
                    end
                    else if (!item.line_in)
                    begin
                        // Device acknowledge
                        state_next.tx_active   = 1'b0;
                        state_next.tx_finished = 1'b1;
                        state_next.tx_position = TX_POS_FIRST;
                    end
                end
            end
            KIND_TX_START:
            begin
                if (!state_reg.tx_active)
                begin
                    state_next.tx_data     = item.send_byte;
                    state_next.tx_active   = 1'b1;
                    state_next.tx_finished = 1'b0;
                    state_next.tx_position = TX_POS_FIRST;
                    state_next.drive_on    = 1'b1;
                    state_next.drive_level = 1'b0;
                end
            end
            KIND_RX_CLEAR:
            begin
                state_next.rx_ready = 1'b0;
            end
            KIND_TX_CLEAR:
            begin
                state_next.tx_finished = 1'b0;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // Report the state after the update
    assign result.line_out    = state_next.drive_level;
    assign result.line_drive  = state_next.drive_on;
    assign result.recv_byte   = state_next.rx_latched;
    assign result.recv_parity = state_next.rx_parity_bit;
    assign result.recv_done   = state_next.rx_ready;
    assign result.send_busy   = state_next.tx_active;
    assign result.send_done   = state_next.tx_finished;

    // Advance the state on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.rx_position   <= RX_POS_IDLE;
            state_reg.rx_shift      <= 8'd0;
            state_reg.rx_latched    <= 8'd0;
            state_reg.rx_parity_bit <= 1'b0;
            state_reg.rx_ready      <= 1'b0;
            state_reg.tx_position   <= TX_POS_FIRST;
            state_reg.tx_data       <= 8'd0;
            state_reg.tx_active     <= 1'b0;
            state_reg.tx_finished   <= 1'b0;
            state_reg.drive_level   <= 1'b1;
            state_reg.drive_on      <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ps2_host_bit_engine.sv
// Top level of the PS/2 host bit engine: input word register, core, result word register.
`timescale 1ns / 1ps
// Accepted words pass the input word register, the core, then the result word register.
// Throughput: one word per cycle unless stalled; each event is one counter/shift update.
// The input register holds a word while the result register is full and stalled.
// Reset (rst_n low, asynchronous): both registers empty, line released at level 1,
// receive and transmit idle with all flags clear.

module ps2_host_bit_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  ps2hbe_pkg::item_t    item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ps2hbe_pkg::result_t  result
);
    import ps2hbe_pkg::*;

    logic    hold_valid_reg;
    item_t   hold_word_reg;
    logic    out_valid_reg;
    result_t out_word_reg;
    logic    advance;
    result_t core_result;

    // Process the held word whenever the result register is free or draining
    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = hold_valid_reg && !advance;

    // Input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (!item_stall)
            hold_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            hold_word_reg <= item;
    end

    ps2hbe_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (hold_valid_reg && advance),
        .item   (hold_word_reg),
        .result (core_result)
    );

    // Result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= hold_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && hold_valid_reg)
            out_word_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

`ifndef SYNTHESIS
    // Busy and done never show together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_word_reg.send_busy && out_word_reg.send_done))
        else $error("send_busy and send_done both set");

    // Host drives the line only during a transmission
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.line_drive |-> out_word_reg.send_busy)
        else $error("line driven without active transmission");

    // A held word with a free result register is delivered next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held word not moved to result register");
`endif

endmodule

### bench/ps2_host_bit_engine_tb.sv
// Testbench for the PS/2 host bit engine: directed frames, random traffic, output stalls.
`timescale 1ns / 1ps

module ps2_host_bit_engine_tb;
    import ps2hbe_pkg::*;

    // Kind code outside the defined event set
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Idle and stall rates in percent, hold request for long output stalls
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_output   = 1'b0;

    int mismatch_count = 0;
    int items_sent     = 0;

    // Expected result words, oldest first
    result_t pending_results[$];

    // Engine copy kept by the testbench
    logic [3:0] rx_pos     = RX_POS_IDLE;
    logic [7:0] rx_shift   = '0;
    logic [7:0] rx_byte    = '0;
    logic       rx_parity  = 1'b0;
    logic       rx_ready   = 1'b0;
    logic [3:0] tx_pos     = TX_POS_FIRST;
    logic [7:0] tx_byte    = '0;
    logic       tx_busy    = 1'b0;
    logic       tx_done    = 1'b0;
    logic       drv_level  = 1'b1;
    logic       drv_on     = 1'b0;

    ps2_host_bit_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Apply one event to the engine copy and return the outputs that follow
    function automatic result_t advance_engine(input item_t w);
        result_t r;
        case (w.kind)
            KIND_RX_EDGE:
            begin
                if (rx_pos == RX_POS_IDLE)
                begin
                    // wait for a low start bit and an empty holding register
                    if (!w.line_in && !rx_ready)
                        rx_pos = RX_POS_DATA0;
                end
                else if (rx_pos <= RX_POS_DATA7)
                begin
                    if (w.line_in)
                        rx_shift[3'(rx_pos - RX_POS_DATA0)] = 1'b1;
                    rx_pos = rx_pos + 4'd1;
                end
                else if (rx_pos == RX_POS_PARITY)
                begin
                    rx_parity = w.line_in;
                    rx_pos    = RX_POS_STOP;
                end
                else if (rx_pos == RX_POS_STOP)
                begin
                    // a low stop bit keeps the frame parked here
                    if (w.line_in)
                    begin
                        rx_byte  = rx_shift;
                        rx_ready = 1'b1;
                        rx_pos   = RX_POS_IDLE;
                        rx_shift = '0;
                    end
                end
                else
                begin
                    rx_pos   = RX_POS_IDLE;
                    rx_shift = '0;
                end
            end
            KIND_TX_EDGE:
            begin
                if (tx_busy)
                begin
                    if (tx_pos < TX_POS_PARITY)
                    begin
                        drv_level = tx_byte[tx_pos[2:0]];
                        tx_pos    = tx_pos + 4'd1;
                    end
                    else if (tx_pos == TX_POS_PARITY)
                    begin
                        drv_level = ^tx_byte;
                        tx_pos    = TX_POS_STOP;
                    end
                    else if (tx_pos == TX_POS_STOP)
                    begin
                        drv_level = 1'b1;
                        drv_on    = 1'b0;
                        tx_pos    = TX_POS_ACK;
                    end
                    else if (!w.line_in)
                    begin
                        // device acknowledge ends the transfer
                        tx_busy = 1'b0;
                        tx_done = 1'b1;
                        tx_pos  = TX_POS_FIRST;
                    end
                end
            end
            KIND_TX_START:
            begin
                if (!tx_busy)
                begin
                    tx_byte   = w.send_byte;
                    tx_busy   = 1'b1;
                    tx_done   = 1'b0;
                    tx_pos    = TX_POS_FIRST;
                    drv_on    = 1'b1;
                    drv_level = 1'b0;
                end
            end
            KIND_RX_CLEAR: rx_ready = 1'b0;
            KIND_TX_CLEAR: tx_done  = 1'b0;
            default: ;
        endcase
        r.line_out    = drv_level;
        r.line_drive  = drv_on;
        r.recv_byte   = rx_byte;
        r.recv_parity = rx_parity;
        r.recv_done   = rx_ready;
        r.send_busy   = tx_busy;
        r.send_done   = tx_done;
        return r;
    endfunction

    // Drive the result stall: forced high during a hold, random otherwise
    always @(negedge clk)
    begin
        if (hold_output)
            result_stall <= 1'b1;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.line_out !== want.line_out)
                begin
                    $error("line_out: expected %0d, got %0d", want.line_out, result.line_out);
                    mismatch_count++;
                end
                if (result.line_drive !== want.line_drive)
                begin
                    $error("line_drive: expected %0d, got %0d",
                           want.line_drive, result.line_drive);
                    mismatch_count++;
                end
                if (result.recv_byte !== want.recv_byte)
                begin
                    $error("recv_byte: expected %02h, got %02h",
                           want.recv_byte, result.recv_byte);
                    mismatch_count++;
                end
                if (result.recv_parity !== want.recv_parity)
                begin
                    $error("recv_parity: expected %0d, got %0d",
                           want.recv_parity, result.recv_parity);
                    mismatch_count++;
                end
                if (result.recv_done !== want.recv_done)
                begin
                    $error("recv_done: expected %0d, got %0d",
                           want.recv_done, result.recv_done);
                    mismatch_count++;
                end
                if (result.send_busy !== want.send_busy)
                begin
                    $error("send_busy: expected %0d, got %0d",
                           want.send_busy, result.send_busy);
                    mismatch_count++;
                end
                if (result.send_done !== want.send_done)
                begin
                    $error("send_done: expected %0d, got %0d",
                           want.send_done, result.send_done);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one input word, hold it until accepted, then record its expectation
    task automatic send_word(input logic [2:0] kind, input logic bit_val,
                             input logic [7:0] data);
        item_t w;
        w.kind      = kind;
        w.line_in   = bit_val;
        w.send_byte = data;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(advance_engine(w));
        items_sent++;
    endtask

    // Send a fully random word, any kind
    task automatic stray_word();
        send_word(3'($urandom_range(7)), 1'($urandom), 8'($urandom));
    endtask

    // Now and then slip a random word into a frame
    task automatic maybe_stray();
        if ($urandom_range(99) < 6)
            stray_word();
    endtask

    // One receive frame with random data, parity and occasional low stop bits
    task automatic recv_frame();
        logic [7:0] data;
        data = 8'($urandom);
        if (rx_ready && $urandom_range(9) < 8)
            send_word(KIND_RX_CLEAR, 1'($urandom), 8'($urandom));
        send_word(KIND_RX_EDGE, 1'b0, 8'($urandom));
        for (int i = 0; i < 8; i++)
        begin
            maybe_stray();
            send_word(KIND_RX_EDGE, data[i], 8'($urandom));
        end
        send_word(KIND_RX_EDGE, 1'($urandom), 8'($urandom));
        while ($urandom_range(9) == 0)
            send_word(KIND_RX_EDGE, 1'b0, 8'($urandom));
        send_word(KIND_RX_EDGE, 1'b1, 8'($urandom));
    endtask

    // One transmit frame: start, data, parity and stop edges, acknowledge after a random wait
    task automatic xmit_frame();
        if (tx_done && $urandom_range(9) < 7)
            send_word(KIND_TX_CLEAR, 1'($urandom), 8'($urandom));
        send_word(KIND_TX_START, 1'($urandom), 8'($urandom));
        repeat (10)
        begin
            maybe_stray();
            send_word(KIND_TX_EDGE, 1'($urandom), 8'($urandom));
        end
        while ($urandom_range(3) == 0)
            send_word(KIND_TX_EDGE, 1'b1, 8'($urandom));
        send_word(KIND_TX_EDGE, 1'b0, 8'($urandom));
    endtask

    // Receive path: idle events, a frame with a low stop bit, start while unread
    task automatic test_receive_frame();
        logic [7:0] data;
        data = 8'h81;
        send_word(KIND_TX_EDGE, 1'b0, 8'h00);
        send_word(KIND_UNUSED, 1'b1, 8'hFF);
        send_word(KIND_RX_EDGE, 1'b0, 8'h00);
        for (int i = 0; i < 8; i++)
            send_word(KIND_RX_EDGE, data[i], 8'h00);
        send_word(KIND_RX_EDGE, 1'b1, 8'h00);
        send_word(KIND_RX_EDGE, 1'b0, 8'h00);
        send_word(KIND_RX_EDGE, 1'b1, 8'h00);
        send_word(KIND_RX_EDGE, 1'b0, 8'h00);
        send_word(KIND_RX_CLEAR, 1'b0, 8'h00);
    endtask

    // Transmit path: all-ones byte, start while busy, late acknowledge
    task automatic test_transmit_frame();
        send_word(KIND_TX_START, 1'b0, 8'hFF);
        send_word(KIND_TX_START, 1'b1, 8'h00);
        repeat (10)
            send_word(KIND_TX_EDGE, 1'b1, 8'h00);
        send_word(KIND_TX_EDGE, 1'b1, 8'h00);
        send_word(KIND_TX_EDGE, 1'b0, 8'h00);
        send_word(KIND_TX_CLEAR, 1'b0, 8'h00);
    endtask

    // Mostly well-formed frames, some noise bursts, under given idle and stall rates
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_rate);
        int target;
        target        = items_sent + count;
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        while (items_sent < target)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: recv_frame();
                4, 5, 6, 7: xmit_frame();
                default: repeat ($urandom_range(6, 1)) stray_word();
            endcase
        end
    endtask

    // Hold the output for a long stretch while words keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                hold_output = 1'b1;
                repeat (200) @(posedge clk);
                hold_output = 1'b0;
            end
            begin
                recv_frame();
                xmit_frame();
                recv_frame();
            end
        join
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_receive_frame();
        test_transmit_frame();
        test_random_traffic(410, 0, 0);
        test_random_traffic(410, 51, 0);
        test_random_traffic(410, 0, 51);
        test_random_traffic(410, 12, 12);
        test_output_backpressure();

        // Drop valid and drain
        @(negedge clk);
        item_valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
rtl/ps2hbe_pkg.sv
rtl/ps2hbe_core.sv
rtl/ps2_host_bit_engine.sv
bench/ps2_host_bit_engine_tb.sv
